FILE: design/grouped_money_text_formatter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grouped money text formatter
// Shorthand for clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef GROUPED_MONEY_TEXT_FORMATTER_MACROS_SVH
`define GROUPED_MONEY_TEXT_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GMTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gmtf_pkg.sv
// ----------------------------------------------------------------------------
// Grouped money text formatter package
// Character codes, configuration register indexes and the job descriptor
// handed from the converter to the character emitter.
// ----------------------------------------------------------------------------
package gmtf_pkg;

  // ASCII characters used in the formatted text.
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COMMA  = 8'h2c;
  localparam logic [7:0] CHAR_PERIOD = 8'h2e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_DECIMAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_COMMA  = 1'b1;

  // Width of the amount field on the input stream.
  localparam int unsigned AMOUNT_W = 64;

  // Per-amount settings travelling with the converted digits.
  typedef struct packed {
    logic negative;
    logic always_decimal;
    logic decimal_comma;
  } job_t;

endpackage

FILE: design/gmtf_bcd_conv.sv
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Takes the two's complement amount, forms its magnitude and shifts it into a
// BCD register one bit per cycle with add-3 correction (double dabble).
// ----------------------------------------------------------------------------
module gmtf_bcd_conv #(
  parameter int VALUE_WIDTH = 64,
  parameter int BCD_DIGITS  = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic                    take,
  output logic                    idle,
  output logic                    result_valid,
  output logic                    negative,
  output logic [BCD_DIGITS*4-1:0] bcd
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                    run_r, run_nxt;
  logic                    hold_r, hold_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0]  mag_r, mag_nxt;
  logic [BCD_DIGITS*4-1:0] bcd_r, bcd_nxt;
  logic                    neg_r, neg_nxt;
  logic [BCD_DIGITS*4-1:0] bcd_adj;
  logic [VALUE_WIDTH-1:0]  value_neg;

  // Add-3 correction on every digit that is five or more.
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  // The magnitude of the most negative value wraps to itself as unsigned.
  assign value_neg = ~value + VALUE_WIDTH'(1);

  // Load on a new request, shift while running, hold until the emitter takes.
  always_comb begin
    run_nxt  = run_r;
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (hold_r && take) begin
      hold_nxt = 1'b0;
    end
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(VALUE_WIDTH);
      neg_nxt = value[VALUE_WIDTH-1];
      mag_nxt = value[VALUE_WIDTH-1] ? value_neg : value;
      bcd_nxt = '0;
    end else if (run_r) begin
      bcd_nxt = {bcd_adj[BCD_DIGITS*4-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        hold_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      hold_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      hold_r <= hold_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign idle         = !run_r && !hold_r;
  assign result_valid = hold_r;
  assign negative     = neg_r;
  assign bcd          = bcd_r;

endmodule

FILE: design/gmtf_char_emit.sv
// ----------------------------------------------------------------------------
// Character emitter
// Walks the BCD digits one per cycle from the top while the output is not held,
// drops leading zeros and streams sign, grouped whole digits, separator and hundredths as ASCII.
// ----------------------------------------------------------------------------
module gmtf_char_emit #(
  parameter int BCD_DIGITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  gmtf_pkg::job_t          job,
  input  logic [BCD_DIGITS*4-1:0] bcd,
  output logic                    job_take,
  output logic                    busy,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,   // [7:0] out_char
  output logic                    out_tlast
);

  localparam int IDX_W    = $clog2(BCD_DIGITS);
  localparam int TOP_LSB  = BCD_DIGITS*4 - 4;
  localparam int IDX_INIT = BCD_DIGITS - 3;
  localparam int MOD_INIT = (BCD_DIGITS - 3) % 3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SKIP  = 4'd1;
  localparam logic [3:0] S_SIGN  = 4'd2;
  localparam logic [3:0] S_DIGIT = 4'd3;
  localparam logic [3:0] S_SPACE = 4'd4;
  localparam logic [3:0] S_SEP   = 4'd5;
  localparam logic [3:0] S_TENS  = 4'd6;
  localparam logic [3:0] S_ONES  = 4'd7;

  logic [3:0]              state_r, state_nxt;
  logic [BCD_DIGITS*4-1:0] dig_r, dig_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [1:0]              mod_r, mod_nxt;
  logic [7:0]              cents_r, cents_nxt;
  logic                    neg_r, neg_nxt;
  logic                    frac_r, frac_nxt;
  logic                    comma_r, comma_nxt;
  logic                    oval_r, oval_nxt;
  logic [7:0]              ochar_r, ochar_nxt;
  logic                    olast_r, olast_nxt;

  logic       out_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;
  logic [3:0] top_dig;

  assign out_free = !oval_r || out_tready;
  assign top_dig  = dig_r[TOP_LSB +: 4];

  // Sequencer: one digit or one character per cycle, a character only when the output is free.
  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    idx_nxt   = idx_r;
    mod_nxt   = mod_r;
    cents_nxt = cents_r;
    neg_nxt   = neg_r;
    frac_nxt  = frac_r;
    comma_nxt = comma_r;
    job_take  = 1'b0;
    emit      = 1'b0;
    emit_char = gmtf_pkg::CHAR_ZERO;
    emit_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_take  = 1'b1;
          dig_nxt   = bcd;
          idx_nxt   = IDX_W'(IDX_INIT);
          mod_nxt   = 2'(MOD_INIT);
          cents_nxt = bcd[7:0];
          neg_nxt   = job.negative;
          frac_nxt  = job.always_decimal || (bcd[7:0] != 8'h00);
          comma_nxt = job.decimal_comma;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros, keeping at least the units digit.
        if (idx_r != '0 && top_dig == 4'h0) begin
          dig_nxt = {dig_r[TOP_LSB-1:0], 4'h0};
          idx_nxt = idx_r - IDX_W'(1);
          mod_nxt = (mod_r == 2'd0) ? 2'd2 : mod_r - 2'd1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = gmtf_pkg::CHAR_MINUS;
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = gmtf_pkg::CHAR_ZERO + {4'h0, top_dig};
          dig_nxt   = {dig_r[TOP_LSB-1:0], 4'h0};
          idx_nxt   = idx_r - IDX_W'(1);
          mod_nxt   = (mod_r == 2'd0) ? 2'd2 : mod_r - 2'd1;
          if (idx_r == '0) begin
            emit_last = !frac_r;
            state_nxt = frac_r ? S_SEP : S_IDLE;
          end else if (mod_r == 2'd0) begin
            state_nxt = S_SPACE;
          end
        end
      end
      S_SPACE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = gmtf_pkg::CHAR_SPACE;
          state_nxt = S_DIGIT;
        end
      end
      S_SEP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = comma_r ? gmtf_pkg::CHAR_COMMA : gmtf_pkg::CHAR_PERIOD;
          state_nxt = S_TENS;
        end
      end
      S_TENS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = gmtf_pkg::CHAR_ZERO + {4'h0, cents_r[7:4]};
          state_nxt = S_ONES;
        end
      end
      S_ONES: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = gmtf_pkg::CHAR_ZERO + {4'h0, cents_r[3:0]};
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loads a new character or drains when taken.
  always_comb begin
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      ochar_nxt = emit_char;
      olast_nxt = emit_last;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    idx_r   <= idx_nxt;
    mod_r   <= mod_nxt;
    cents_r <= cents_nxt;
    neg_r   <= neg_nxt;
    frac_r  <= frac_nxt;
    comma_r <= comma_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule

FILE: design/grouped_money_text_formatter.sv
// Flow: the converter forms the magnitude and runs double dabble; the emitter skips leading
//   zero digits (at most BCD_DIGITS-3), then streams one character a cycle while not stalled.
// Overlap: a new amount is accepted once the emitter has taken the previous digits, while
//   it still streams them; with a freely draining output, double dabble sets the rate.
// Reset: clears all control state; always_decimal resets to 0, decimal_comma to 1.
// ----------------------------------------------------------------------------
// Grouped money text formatter
// Converts a signed amount in hundredths to ASCII text with a space every
// three whole digits and an optional two-digit fraction, one character a beat.
// ----------------------------------------------------------------------------
`include "grouped_money_text_formatter_macros.svh"

module grouped_money_text_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gmtf_pkg::AMOUNT_W-1:0]  in_tdata,    // [63:0] amount
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,   // [7:0] out_char
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [gmtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]                     cfg_wdata
);

  localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  logic                    always_decimal_r, always_decimal_nxt;
  logic                    decimal_comma_r, decimal_comma_nxt;
  logic                    conv_idle;
  logic                    conv_valid;
  logic                    conv_neg;
  logic [BCD_DIGITS*4-1:0] conv_bcd;
  logic                    job_take;
  logic                    emit_busy;
  logic                    in_accept;
  gmtf_pkg::job_t          job;

  assign in_tready = conv_idle;
  assign in_accept = in_tvalid && in_tready;

  // Configuration register writes.
  always_comb begin
    always_decimal_nxt = always_decimal_r;
    decimal_comma_nxt  = decimal_comma_r;
    if (cfg_we) begin
      case (cfg_index)
        gmtf_pkg::CFG_ALWAYS_DECIMAL: always_decimal_nxt = cfg_wdata[0];
        gmtf_pkg::CFG_DECIMAL_COMMA:  decimal_comma_nxt  = cfg_wdata[0];
        default: begin
          always_decimal_nxt = always_decimal_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      always_decimal_r <= 1'b0;
      decimal_comma_r  <= 1'b1;
    end else begin
      always_decimal_r <= always_decimal_nxt;
      decimal_comma_r  <= decimal_comma_nxt;
    end
  end

  // Settings that go with the converted amount.
  assign job.negative       = conv_neg;
  assign job.always_decimal = always_decimal_r;
  assign job.decimal_comma  = decimal_comma_r;

  gmtf_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .BCD_DIGITS  (BCD_DIGITS)
  ) u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_accept),
    .value        (in_tdata[VALUE_WIDTH-1:0]),
    .take         (job_take),
    .idle         (conv_idle),
    .result_valid (conv_valid),
    .negative     (conv_neg),
    .bcd          (conv_bcd)
  );

  gmtf_char_emit #(
    .BCD_DIGITS (BCD_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (conv_valid),
    .job        (job),
    .bcd        (conv_bcd),
    .job_take   (job_take),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A new request keeps the converter occupied on the following cycle.
  `GMTF_ASSERT_NEXT(a_conv_busy_after_request, in_accept, !in_tready, "converter idle after request")
  // Digits handed over start the emitter sequence.
  `GMTF_ASSERT_NEXT(a_emit_starts_on_take, job_take, emit_busy, "emitter did not start on handoff")
  // Text never ends in a sign or a group space.
  `GMTF_ASSERT_NOW(a_last_char_kind, out_tvalid && out_tlast, out_tdata != gmtf_pkg::CHAR_MINUS && out_tdata != gmtf_pkg::CHAR_SPACE, "bad final character")

endmodule
